>>> design/assert_macros.svh
// assertion macros used by the allocator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("allocator assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("allocator assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

>>> design/rpa_pkg.sv
// types, constants and codes of the page allocator
package rpa_pkg;

   localparam int PAGES      = 65536;
   localparam int PAGE_BITS  = $clog2(PAGES);
   localparam int TOP_W      = PAGE_BITS + 1;
   localparam int PAGE_SHIFT = 12;
   localparam int REF_BITS   = 8;
   localparam int ADDR_W     = 32;
   localparam int CMP_W      = ADDR_W + 1;
   localparam int FUNC_W     = 3;
   localparam int COUNT_W    = 8;
   localparam int FREE_W     = 17;
   localparam int FIRST_W    = 16;
   localparam int LIMIT_W    = 17;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_PAGE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_PAGE = 1'd1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC = 3'd0,
      FUNC_FREE  = 3'd1,
      FUNC_ADD   = 3'd2,
      FUNC_DROP  = 3'd3,
      FUNC_READ  = 3'd4,
      FUNC_SEED  = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_MEM   = 2'd1,
      STATUS_BAD_ADDR = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] phys_address;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  page_address;
      logic [COUNT_W-1:0] ref_count;
      logic [FREE_W-1:0]  free_pages;
      logic               released;
   } rsp_type;

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage

>>> design/rpa_ctrl.sv
// sequencer of the page allocator: clearing pass, accept, execute, result hand-off
module rpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rpa_pkg::dp_status_type dp_status,
   output rpa_pkg::dp_cmd_type    dp_cmd
);
   import rpa_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            dp_cmd.clear_en = 1'b1;
            if (dp_status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.accept = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // results land only when the output register is free or emptying
            if (!rsp_valid_ff || !rsp_stall) begin
               dp_cmd.commit = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   assign rsp_valid_in = dp_cmd.commit | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign req_stall    = (state_ff != ST_IDLE);

endmodule

>>> design/rpa_datapath.sv
// datapath of the page allocator: count table, free stack, settings and result register
module rpa_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  rpa_pkg::dp_cmd_type               dp_cmd,
   output rpa_pkg::dp_status_type            dp_status,
   input  rpa_pkg::req_type                  req_data,
   output rpa_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [rpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rpa_pkg::CSR_DATA_W-1:0]    csr_data
);
   import rpa_pkg::*;

   logic [REF_BITS-1:0]  ref_mem_ff [PAGES];
   logic [PAGE_BITS-1:0] stack_mem_ff [PAGES];

   logic [TOP_W-1:0]     stack_top_ff, stack_top_in;
   logic [PAGE_BITS-1:0] clr_cnt_ff;
   logic [FIRST_W-1:0]   first_page_ff;
   logic [LIMIT_W-1:0]   limit_page_ff;
   req_type              req_ff;
   logic [REF_BITS-1:0]  ref_rd_ff;
   logic [PAGE_BITS-1:0] stk_rd_ff;
   rsp_type              rsp_ff, rsp_in;

   logic [CMP_W-1:0]     in_page_ext;
   logic [PAGE_BITS-1:0] in_page_idx;
   logic [PAGE_BITS-1:0] top_m1;

   logic [CMP_W-1:0]     page_ext;
   logic [PAGE_BITS-1:0] page_idx;
   logic                 aligned;
   logic                 page_ok;
   logic                 above_first;
   logic                 stack_empty;
   logic                 stack_full;
   logic [REF_BITS-1:0]  c_base;
   logic [REF_BITS-1:0]  c_new;
   logic                 ref_wr;
   logic [PAGE_BITS-1:0] ref_wa;
   logic [REF_BITS-1:0]  ref_wd;
   logic                 push;
   logic                 pop;

   logic                 mem_we;
   logic [PAGE_BITS-1:0] mem_wa;
   logic [REF_BITS-1:0]  mem_wd;

   // the count table read address comes straight from the incoming transfer, the stack's from its top
   assign in_page_ext = CMP_W'(req_data.phys_address >> PAGE_SHIFT);
   assign in_page_idx = in_page_ext[PAGE_BITS-1:0];
   assign top_m1      = PAGE_BITS'(stack_top_ff - TOP_W'(1));

   assign mem_we = dp_cmd.clear_en | (dp_cmd.commit & ref_wr);
   assign mem_wa = dp_cmd.clear_en ? clr_cnt_ff : ref_wa;
   assign mem_wd = dp_cmd.clear_en ? '0 : ref_wd;

   always_ff @(posedge clock) begin
      if (mem_we) ref_mem_ff[mem_wa] <= mem_wd;
      if (dp_cmd.accept) ref_rd_ff <= ref_mem_ff[in_page_idx];
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.commit && push) stack_mem_ff[stack_top_ff[PAGE_BITS-1:0]] <= page_idx;
      if (dp_cmd.accept) stk_rd_ff <= stack_mem_ff[top_m1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_top_ff  <= '0;
         clr_cnt_ff    <= '0;
         first_page_ff <= '0;
         limit_page_ff <= LIMIT_RESET;
      end else begin
         if (dp_cmd.commit) stack_top_ff <= stack_top_in;
         if (dp_cmd.clear_en) clr_cnt_ff <= clr_cnt_ff + PAGE_BITS'(1);
         if (csr_we) begin
            unique case (csr_index)
               CSR_FIRST_PAGE: first_page_ff <= csr_data[FIRST_W-1:0];
               CSR_LIMIT_PAGE: limit_page_ff <= csr_data[LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.accept) req_ff <= req_data;
      if (dp_cmd.commit) rsp_ff <= rsp_in;
   end

   assign dp_status.clear_last = (clr_cnt_ff == '1);

   assign page_ext    = CMP_W'(req_ff.phys_address >> PAGE_SHIFT);
   assign page_idx    = page_ext[PAGE_BITS-1:0];
   assign aligned     = (req_ff.phys_address[PAGE_SHIFT-1:0] == '0);
   assign page_ok     = (page_ext < CMP_W'(limit_page_ff)) && (page_ext < CMP_W'(PAGES));
   assign above_first = (page_ext >= CMP_W'(first_page_ff));
   assign stack_empty = (stack_top_ff == '0);
   assign stack_full  = (stack_top_ff == TOP_W'(PAGES));

   always_comb begin
      rsp_in       = '0;
      rsp_in.status = STATUS_OK;
      ref_wr       = 1'b0;
      ref_wa       = page_idx;
      ref_wd       = '0;
      push         = 1'b0;
      pop          = 1'b0;
      c_base       = '0;
      c_new        = '0;
      unique case (req_ff.func) inside
         FUNC_ALLOC: begin
            if (stack_empty) begin
               rsp_in.status = STATUS_NO_MEM;
            end else begin
               pop                 = 1'b1;
               ref_wr              = 1'b1;
               ref_wa              = stk_rd_ff;
               ref_wd              = REF_BITS'(1);
               rsp_in.ref_count    = COUNT_W'(1);
               rsp_in.page_address = ADDR_W'({stk_rd_ff, {PAGE_SHIFT{1'b0}}});
            end
         end
         FUNC_FREE, FUNC_SEED: begin
            if (!aligned || !above_first || !page_ok) begin
               rsp_in.status = STATUS_BAD_ADDR;
            end else begin
               // seed clears the count first, then behaves as a free
               c_base = (req_ff.func == FUNC_SEED) ? '0 : ref_rd_ff;
               c_new  = (c_base != '0) ? c_base - REF_BITS'(1) : '0;
               ref_wr = 1'b1;
               ref_wd = c_new;
               rsp_in.ref_count = COUNT_W'(c_new);
               if (c_new == '0) begin
                  if (stack_full) begin
                     rsp_in.status = STATUS_OVERFLOW;
                  end else begin
                     push            = 1'b1;
                     rsp_in.released = 1'b1;
                  end
               end
            end
         end
         FUNC_ADD, FUNC_DROP, FUNC_READ: begin
            if (!page_ok) begin
               rsp_in.status = STATUS_BAD_ADDR;
            end else begin
               c_base = ref_rd_ff;
               c_new  = c_base;
               if (req_ff.func == FUNC_ADD && c_base != '1) c_new = c_base + REF_BITS'(1);
               if (req_ff.func == FUNC_DROP && c_base != '0) c_new = c_base - REF_BITS'(1);
               ref_wr = 1'b1;
               ref_wd = c_new;
               rsp_in.ref_count = COUNT_W'(c_new);
            end
         end
         default: ;
      endcase
      stack_top_in = stack_top_ff;
      if (pop) stack_top_in = stack_top_ff - TOP_W'(1);
      if (push) stack_top_in = stack_top_ff + TOP_W'(1);
      rsp_in.free_pages = FREE_W'(stack_top_in);
   end

   assign rsp_data = rsp_ff;

endmodule

>>> design/refcounted_page_allocator.sv
// top level of the reference-counted physical page allocator
// rsp_valid rises after the request transfer and the execute state; execute waits while a stalled
// result fills the output register; requests are taken one at a time, for the count table read then write
// a result waiting in the output register does not hold back the next request transfer
// reset: synchronous; then a pass over all 65536 entries clears the count table with req_stall high,
// settings writes are taken throughout
module refcounted_page_allocator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  rpa_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rpa_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rpa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rpa_pkg::CSR_DATA_W-1:0] csr_data
);
   import rpa_pkg::*;

`include "assert_macros.svh"

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   rpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   rpa_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // one request at a time: busy right after a transfer
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `ASSERT_IMPLIES(a_free_bound, clock, reset, rsp_valid, rsp_data.free_pages <= FREE_W'(PAGES))
   `ASSERT_IMPLIES(a_release_ok, clock, reset, rsp_valid && rsp_data.released, rsp_data.status == STATUS_OK)
   `ASSERT_IMPLIES(a_addr_on_ok, clock, reset, rsp_valid && rsp_data.status != STATUS_OK, rsp_data.page_address == '0)

endmodule

>>> tb/tb_top.sv
// self-checking testbench of the reference-counted page allocator
`timescale 1ns / 1ps

module tb_top;
   import rpa_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_RSVD_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_RSVD_HI = 3'd7;
   localparam bit CHECKED   = 1'b1;
   localparam bit PREDICTED = 1'b0;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int HOLD_CYCLES    = 400;
   localparam int MAX_REPORTS    = 40;

   typedef struct packed {
      bit      typed;
      req_type item;
      rsp_type want;
   } page_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FIRST_PAGE;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // shadow of the allocator
   logic [PAGE_BITS-1:0] free_list [PAGES];
   logic [COUNT_W-1:0] page_refs [PAGES];
   logic [TOP_W-1:0] free_depth;
   logic [FIRST_W-1:0] cfg_first;
   logic [LIMIT_W-1:0] cfg_limit;

   rsp_type results_due [$];
   page_row_type directed_rows [$];

   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int stuck_cycles = 0;
   int mismatch_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int window_count = 0;
   int no_mem_seen = 0;
   int bad_addr_seen = 0;
   int overflow_seen = 0;
   int released_seen = 0;

   refcounted_page_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic rsp_type apply_page_op(input req_type item);
      rsp_type r;
      logic [ADDR_W-PAGE_SHIFT-1:0] pg;
      logic [PAGE_BITS-1:0] pn;
      logic [COUNT_W-1:0] c;
      logic in_range;
      r = '0;
      pg = item.phys_address[ADDR_W-1:PAGE_SHIFT];
      pn = pg[PAGE_BITS-1:0];
      in_range = (pg < cfg_limit) && (pg < PAGES);
      case (item.func)
         FUNC_ALLOC: begin
            if (free_depth == 0) begin
               r.status = STATUS_NO_MEM;
            end else begin
               free_depth = free_depth - 1'b1;
               pn = free_list[free_depth];
               page_refs[pn] = 8'd1;
               r.ref_count = 8'd1;
               r.page_address = {{(ADDR_W-PAGE_BITS){1'b0}}, pn} << PAGE_SHIFT;
            end
         end
         FUNC_FREE, FUNC_SEED: begin
            if (item.phys_address[PAGE_SHIFT-1:0] != 0 || pg < cfg_first || !in_range) begin
               r.status = STATUS_BAD_ADDR;
            end else begin
               if (item.func == FUNC_SEED)
                  page_refs[pn] = '0;
               c = page_refs[pn];
               if (c != 0) begin
                  c = c - 1'b1;
                  page_refs[pn] = c;
               end
               // count at zero: push, unless the stack is already full
               if (c == 0) begin
                  if (free_depth >= PAGES) begin
                     r.status = STATUS_OVERFLOW;
                  end else begin
                     free_list[free_depth] = pn;
                     free_depth = free_depth + 1'b1;
                     r.released = 1'b1;
                  end
               end
               r.ref_count = page_refs[pn];
            end
         end
         FUNC_ADD, FUNC_DROP, FUNC_READ: begin
            if (!in_range) begin
               r.status = STATUS_BAD_ADDR;
            end else begin
               c = page_refs[pn];
               if (item.func == FUNC_ADD && c != {COUNT_W{1'b1}})
                  c = c + 1'b1;
               else if (item.func == FUNC_DROP && c != 0)
                  c = c - 1'b1;
               page_refs[pn] = c;
               r.ref_count = c;
            end
         end
         default: ;
      endcase
      r.free_pages = free_depth;
      return r;
   endfunction

   function automatic page_row_type stim_row(input bit typed, input logic [FUNC_W-1:0] fn,
                                             input logic [ADDR_W-1:0] addr,
                                             input status_type st,
                                             input logic [ADDR_W-1:0] pa,
                                             input logic [COUNT_W-1:0] cnt,
                                             input logic [FREE_W-1:0] fr, input logic rel);
      page_row_type row;
      row.typed = typed;
      row.item.func = fn;
      row.item.phys_address = addr;
      row.want.status = st;
      row.want.page_address = pa;
      row.want.ref_count = cnt;
      row.want.free_pages = fr;
      row.want.released = rel;
      return row;
   endfunction

   // mostly a small window of pages from first_page up, some edges, some noise
   function automatic req_type random_page_op();
      req_type item;
      int unsigned roll;
      int unsigned lo;
      int unsigned hi;
      logic [ADDR_W-PAGE_SHIFT-1:0] pg;
      logic [PAGE_SHIFT-1:0] offset;
      roll = $urandom_range(99);
      if (roll < 25)
         item.func = FUNC_ALLOC;
      else if (roll < 43)
         item.func = FUNC_FREE;
      else if (roll < 58)
         item.func = FUNC_ADD;
      else if (roll < 68)
         item.func = FUNC_DROP;
      else if (roll < 76)
         item.func = FUNC_READ;
      else if (roll < 94)
         item.func = FUNC_SEED;
      else
         item.func = ($urandom_range(1) == 0) ? FUNC_RSVD_LO : FUNC_RSVD_HI;
      lo = cfg_first;
      hi = (cfg_limit < lo + 8) ? cfg_limit : lo + 8;
      roll = $urandom_range(99);
      if (roll < 75) begin
         pg = (hi > lo) ? 20'(lo + $urandom_range(hi - lo - 1)) : 20'(lo);
      end else if (roll < 90) begin
         case ($urandom_range(4))
            0: pg = 20'(lo - 1);
            1: pg = 20'(cfg_limit - 1'b1);
            2: pg = 20'(cfg_limit);
            3: pg = 20'(PAGES - 1);
            default: pg = '0;
         endcase
      end else begin
         pg = 20'($urandom);
      end
      offset = ($urandom_range(99) < 85) ? '0 : 12'($urandom);
      item.phys_address = {pg, offset};
      return item;
   endfunction

   task automatic report_field(input string field, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
   endtask

   task automatic check_page_result(input rsp_type got);
      rsp_type want;
      checked_count++;
      if (results_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result %h arrived with no request outstanding", $time, got);
      end else begin
         want = results_due.pop_front();
         if (got.status !== want.status)
            report_field("status", want.status, got.status);
         if (got.page_address !== want.page_address)
            report_field("page_address", want.page_address, got.page_address);
         if (got.ref_count !== want.ref_count)
            report_field("ref_count", want.ref_count, got.ref_count);
         if (got.free_pages !== want.free_pages)
            report_field("free_pages", want.free_pages, got.free_pages);
         if (got.released !== want.released)
            report_field("released", want.released, got.released);
         case (want.status)
            STATUS_NO_MEM:   no_mem_seen++;
            STATUS_BAD_ADDR: bad_addr_seen++;
            STATUS_OVERFLOW: overflow_seen++;
            default: ;
         endcase
         if (want.released)
            released_seen++;
      end
   endtask

   task automatic send_page_op(input req_type item, input bit typed, input rsp_type want);
      rsp_type predicted;
      while (!quiet && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      // shadow state moves in transfer order, typed rows override the prediction
      predicted = apply_page_op(item);
      results_due.push_back(typed ? want : predicted);
      sent_count++;
   endtask

   // both registers in one held-valid sequence, only once the block has drained
   task automatic set_page_window(input logic [FIRST_W-1:0] first,
                                  input logic [LIMIT_W-1:0] limit);
      req_valid <= 1'b0;
      while (results_due.size() != 0)
         @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_FIRST_PAGE;
      csr_data <= {1'b0, first};
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_index <= CSR_LIMIT_PAGE;
      csr_data <= limit;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      cfg_first = first;
      cfg_limit = limit;
      window_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         check_page_result(rsp_data);
   end

   // receiver: random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_request && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 11);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      logic [FIRST_W-1:0] first;
      logic [LIMIT_W-1:0] limit;
      int count;
      logic [ADDR_W-PAGE_SHIFT-1:0] hot_page;
      req_type op;
      for (int i = 0; i < PAGES; i++)
         page_refs[i] = '0;
      free_depth = '0;
      cfg_first = '0;
      cfg_limit = LIMIT_RESET;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      set_page_window(16'd4, 17'd64);

      // window is pages 4 to 63
      directed_rows.push_back(stim_row(CHECKED, FUNC_ALLOC, 32'h0000_0000,
                                       STATUS_NO_MEM, 32'h0, 8'd0, 17'd0, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_READ, 32'h0000_5000,
                                       STATUS_OK, 32'h0, 8'd0, 17'd0, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_FREE, 32'h0000_5001,
                                       STATUS_BAD_ADDR, 32'h0, 8'd0, 17'd0, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_FREE, 32'h0000_3000,
                                       STATUS_BAD_ADDR, 32'h0, 8'd0, 17'd0, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_SEED, 32'h0004_0000,
                                       STATUS_BAD_ADDR, 32'h0, 8'd0, 17'd0, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_READ, 32'hFFFF_FFFF,
                                       STATUS_BAD_ADDR, 32'h0, 8'd0, 17'd0, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_SEED, 32'h0000_4000,
                                       STATUS_OK, 32'h0, 8'd0, 17'd1, 1'b1));
      directed_rows.push_back(stim_row(CHECKED, FUNC_SEED, 32'h0003_F000,
                                       STATUS_OK, 32'h0, 8'd0, 17'd2, 1'b1));
      directed_rows.push_back(stim_row(CHECKED, FUNC_ALLOC, 32'h0000_0000,
                                       STATUS_OK, 32'h0003_F000, 8'd1, 17'd1, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_ADD, 32'h0003_F123,
                                       STATUS_OK, 32'h0, 8'd2, 17'd1, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_DROP, 32'h0003_FFFF,
                                       STATUS_OK, 32'h0, 8'd1, 17'd1, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_FREE, 32'h0003_F000,
                                       STATUS_OK, 32'h0, 8'd0, 17'd2, 1'b1));
      // count already zero: pushed a second time
      directed_rows.push_back(stim_row(CHECKED, FUNC_FREE, 32'h0003_F000,
                                       STATUS_OK, 32'h0, 8'd0, 17'd3, 1'b1));
      directed_rows.push_back(stim_row(CHECKED, FUNC_DROP, 32'h0000_4000,
                                       STATUS_OK, 32'h0, 8'd0, 17'd3, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_ADD, 32'h0000_0000,
                                       STATUS_OK, 32'h0, 8'd1, 17'd3, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_FREE, 32'h0000_0000,
                                       STATUS_BAD_ADDR, 32'h0, 8'd0, 17'd3, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_SEED, 32'h0000_0000,
                                       STATUS_BAD_ADDR, 32'h0, 8'd0, 17'd3, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_RSVD_LO, 32'h0000_1000,
                                       STATUS_OK, 32'h0, 8'd0, 17'd3, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_RSVD_HI, 32'hFFFF_FFFF,
                                       STATUS_OK, 32'h0, 8'd0, 17'd3, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_ALLOC, 32'hFFFF_FFFF,
                                       STATUS_OK, 32'h0003_F000, 8'd1, 17'd2, 1'b0));
      directed_rows.push_back(stim_row(PREDICTED, FUNC_ADD, 32'h0003_F000,
                                       STATUS_OK, 32'h0, 8'd0, 17'd0, 1'b0));
      directed_rows.push_back(stim_row(PREDICTED, FUNC_SEED, 32'h0003_F000,
                                       STATUS_OK, 32'h0, 8'd0, 17'd0, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_ALLOC, 32'h0000_0000,
                                       STATUS_OK, 32'h0003_F000, 8'd1, 17'd2, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_ALLOC, 32'h0000_0000,
                                       STATUS_OK, 32'h0003_F000, 8'd1, 17'd1, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_ALLOC, 32'h0000_0000,
                                       STATUS_OK, 32'h0000_4000, 8'd1, 17'd0, 1'b0));
      directed_rows.push_back(stim_row(CHECKED, FUNC_ALLOC, 32'h0000_0000,
                                       STATUS_NO_MEM, 32'h0, 8'd0, 17'd0, 1'b0));

      foreach (directed_rows[i])
         send_page_op(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin first = 16'd0;     limit = LIMIT_RESET; count = 150; end
            1: begin first = 16'd65535; limit = LIMIT_RESET; count = 150; end
            2: begin first = 16'd0;     limit = 17'd1;       count = 150; end
            3: begin first = 16'd300;   limit = 17'd200;     count = 100; end
            4: begin
               first = 16'($urandom_range(60000));
               limit = 17'($urandom_range(PAGES, first + 1));
               count = 150;
            end
            default: begin first = 16'd100; limit = 17'd140; count = 150; end
         endcase
         set_page_window(first, limit);
         quiet <= (ph == 1);
         if (ph == 4)
            hold_request <= 1'b1;
         for (int n = 0; n < count; n++) begin
            // drive one page to the top of its count and back to zero
            if (ph == 5 && n == 75) begin
               hot_page = 20'(cfg_first + $urandom_range(39));
               for (int k = 0; k < 2 * 258; k++) begin
                  op.func = (k < 258) ? FUNC_ADD : FUNC_DROP;
                  op.phys_address = {hot_page, 12'($urandom)};
                  send_page_op(op, PREDICTED, '0);
               end
            end
            send_page_op(random_page_op(), PREDICTED, '0);
         end
      end

      // full memory range: seed a page, take a reference, free it again
      set_page_window(16'd0, LIMIT_RESET);
      hot_page = 20'($urandom_range(PAGES - 1));
      op.phys_address = {hot_page, 12'h000};
      op.func = FUNC_SEED;
      send_page_op(op, PREDICTED, '0);
      op.func = FUNC_ADD;
      send_page_op(op, PREDICTED, '0);
      op.func = FUNC_FREE;
      send_page_op(op, PREDICTED, '0);
      for (int n = 0; n < 40; n++)
         send_page_op(random_page_op(), PREDICTED, '0);
      req_valid <= 1'b0;

      while (results_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d requests under %0d page windows, %0d results checked, %0d mismatches",
               sent_count, window_count, checked_count, mismatch_count);
      $display("seen: %0d out of memory, %0d bad address, %0d stack overflow, %0d pushes",
               no_mem_seen, bad_addr_seen, overflow_seen, released_seen);
      if (mismatch_count == 0 && results_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/rpa_pkg.sv
design/rpa_ctrl.sv
design/rpa_datapath.sv
design/refcounted_page_allocator.sv
tb/tb_top.sv
